### sv/sld_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the segment length and direction block.
// Depends on nothing; every module of the block imports it.
package sld_pkg;

  // Coordinate and unit formats
  localparam int COORD_BITS     = 24;
  localparam int UNIT_FRAC_BITS = 15;

  // Derived widths
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MAG_W      = COORD_BITS;
  localparam int SQ_W       = 2 * COORD_BITS + 2;
  localparam int EXTRA_BITS = (61 - 2 * COORD_BITS) / 2;
  localparam int X_W        = SQ_W + 2 * EXTRA_BITS;
  localparam int ROOT_W     = X_W / 2;
  localparam int LEN_W      = COORD_BITS + 2;
  localparam int UNIT_W     = UNIT_FRAC_BITS + 1;
  localparam int Q_W        = UNIT_FRAC_BITS + 3;
  localparam int DEN_W      = ROOT_W + 1;
  localparam int REM_W      = DEN_W + Q_W;
  localparam int NUM_SHIFT  = UNIT_FRAC_BITS + EXTRA_BITS + 1;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Quotient of an exact unit magnitude
  localparam logic [Q_W-1:0] UNIT_FULL = Q_W'(1) << UNIT_FRAC_BITS;

  // Classified segment, as queued between front and back
  typedef struct packed {
    logic [2:0]            neg_dir;
    logic [2:0][MAG_W-1:0] mag;
    logic [SQ_W-1:0]       sum_sq;
    logic                  neg_len;
    logic                  zero;
  } sld_item_t;

  // Square root pipeline stage
  typedef struct packed {
    logic [X_W-1:0]        rem;
    logic [ROOT_W-1:0]     root;
    logic [2:0]            neg_dir;
    logic [2:0][MAG_W-1:0] mag;
    logic                  neg_len;
    logic                  zero;
  } sld_sq_t;

  // Divider pipeline stage
  typedef struct packed {
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][Q_W-1:0]   quo;
    logic [DEN_W-1:0]      den;
    logic [LEN_W-1:0]      len;
    logic [2:0]            neg_dir;
    logic                  zero;
  } sld_dv_t;

endpackage

### sv/segment_length_and_direction.sv
`timescale 1ns / 1ps
// Segment length and unit direction: top level.
// Channels: an input beat carries two 3D endpoints in signed Q12.12 and a
// prior_negative flag; an output beat carries the length (signed Q14.12,
// negated when prior_negative is set), the unit direction in signed Q1.15
// (an exact +1 saturates to 32767) and a zero_length flag that is set, with
// every other field zero, when the endpoints coincide.
// Throughput: one segment per cycle while the output is not held off. The
// square root runs as a 31-stage pipeline, one root bit per stage, and the
// three divisions as 18-stage pipelines, one quotient bit per stage, so
// nothing is shared between items. An accepted beat is written into the
// queue, then passes the root stages, the division stages and the output
// register.
// Stall: when the output is held off, the whole back pipeline freezes and
// the 4-deep front queue keeps taking beats until it fills.
// Reset: asynchronous, active low; clears the queue and all valid bits.
// Depends on sld_pkg, sld_front, sld_fifo and sld_back.
module segment_length_and_direction
  import sld_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] end_z_i,
  input  logic                         prior_negative_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [LEN_W-1:0]      seg_length_o,
  output logic signed [UNIT_W-1:0]     unit_x_o,
  output logic signed [UNIT_W-1:0]     unit_y_o,
  output logic signed [UNIT_W-1:0]     unit_z_o,
  output logic                         zero_length_o
);

  sld_item_t front_item, back_item;
  logic      front_valid, front_ready, back_valid, back_ready;

  // Classify incoming segments
  sld_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .start_z_i        (start_z_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .end_z_i          (end_z_i),
    .prior_negative_i (prior_negative_i),
    .item_valid_o     (front_valid),
    .item_ready_i     (front_ready),
    .item_o           (front_item)
  );

  // Decouple front and back
  sld_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  // Compute length and direction
  sld_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (back_valid),
    .item_ready_o  (back_ready),
    .item_i        (back_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .seg_length_o  (seg_length_o),
    .unit_x_o      (unit_x_o),
    .unit_y_o      (unit_y_o),
    .unit_z_o      (unit_z_o),
    .zero_length_o (zero_length_o)
  );

endmodule

### sv/sld_front.sv
`timescale 1ns / 1ps
// Front end: takes a segment beat, forms the differences, magnitudes and
// the sum of squares, and flags coincident endpoints. Uses sld_pkg.
module sld_front
  import sld_pkg::*;
(
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] end_z_i,
  input  logic                         prior_negative_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output sld_item_t                    item_o
);

  logic signed [DIFF_W-1:0] diff [3];
  logic [MAG_W-1:0]         mag  [3];
  logic [2*MAG_W-1:0]       prod [3];
  logic [SQ_W-1:0]          sum_sq;

  // Form differences end minus start
  always_comb begin
    diff[0] = DIFF_W'(end_x_i) - DIFF_W'(start_x_i);
    diff[1] = DIFF_W'(end_y_i) - DIFF_W'(start_y_i);
    diff[2] = DIFF_W'(end_z_i) - DIFF_W'(start_z_i);
  end

  // Take magnitudes and squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]  = diff[k][DIFF_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
      prod[k] = mag[k] * mag[k];
    end
    sum_sq = SQ_W'(prod[0]) + SQ_W'(prod[1]) + SQ_W'(prod[2]);
  end

  // Pack the classified item
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      item_o.neg_dir[k] = diff[k][DIFF_W-1];
      item_o.mag[k]     = mag[k];
    end
    item_o.sum_sq  = sum_sq;
    item_o.neg_len = prior_negative_i;
    item_o.zero    = (sum_sq == '0);
  end

  assign item_valid_o = in_valid_i;
  assign in_ready_o   = item_ready_i;

endmodule

### sv/sld_fifo.sv
`timescale 1ns / 1ps
// Short queue that decouples the front end from the arithmetic back end.
// Uses sld_pkg for the item type and depth.
module sld_fifo
  import sld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  sld_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output sld_item_t pop_item_o
);

  sld_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Store a beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

### sv/sld_back.sv
`timescale 1ns / 1ps
// Back end: pipelined square root, three pipelined dividers, saturation
// and the output register. Uses sld_pkg.
module sld_back
  import sld_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  sld_item_t                item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [LEN_W-1:0]  seg_length_o,
  output logic signed [UNIT_W-1:0] unit_x_o,
  output logic signed [UNIT_W-1:0] unit_y_o,
  output logic signed [UNIT_W-1:0] unit_z_o,
  output logic                     zero_length_o
);

  logic              adv, pop;
  logic [ROOT_W:0]   sq_valid_q;
  logic [Q_W:0]      dv_valid_q;
  sld_sq_t           sq_q [ROOT_W+1];
  sld_dv_t           dv_q [Q_W+1];
  sld_sq_t           sq_in;
  sld_dv_t           dv_in;
  logic [LEN_W-1:0]  len_u;
  logic              out_valid_q;
  logic [LEN_W-1:0]  len_q;
  logic [UNIT_W-1:0] unit_q [3];
  logic              zero_q;
  logic [UNIT_W-1:0] unit_d [3];
  logic [Q_W-1:0]    q_sat  [3];

  // Advance the whole pipeline while the output slot is free or draining
  assign adv          = !out_valid_q || out_ready_i;
  assign pop          = adv && item_valid_i;
  assign item_ready_o = adv;

  // Load the root stage
  always_comb begin
    sq_in.rem     = X_W'(item_i.sum_sq) << (2 * EXTRA_BITS);
    sq_in.root    = '0;
    sq_in.neg_dir = item_i.neg_dir;
    sq_in.mag     = item_i.mag;
    sq_in.neg_len = item_i.neg_len;
    sq_in.zero    = item_i.zero;
  end

  always_ff @(posedge clk_i) begin
    if (adv) sq_q[0] <= sq_in;
  end

  // One root bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - j;
    logic [X_W:0] trial;
    sld_sq_t      nxt;
    always_comb begin
      nxt   = sq_q[j];
      trial = ({1'b0, {(X_W-ROOT_W){1'b0}}, sq_q[j].root} << (B + 1))
              + ((X_W+1)'(1) << (2 * B));
      if ({1'b0, sq_q[j].rem} >= trial) begin
        nxt.rem  = sq_q[j].rem - trial[X_W-1:0];
        nxt.root = sq_q[j].root | (ROOT_W'(1) << B);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[j+1] <= nxt;
    end
  end

  // Round the length and set up the divisions
  always_comb begin
    len_u = LEN_W'(sq_q[ROOT_W].root >> EXTRA_BITS)
            + LEN_W'(sq_q[ROOT_W].root[EXTRA_BITS-1]);
    dv_in.len = sq_q[ROOT_W].neg_len ? -len_u : len_u;
    for (int k = 0; k < 3; k++) begin
      dv_in.rem[k] = (REM_W'(sq_q[ROOT_W].mag[k]) << NUM_SHIFT)
                     + REM_W'(sq_q[ROOT_W].root);
      dv_in.quo[k] = '0;
    end
    dv_in.den     = {sq_q[ROOT_W].root, 1'b0};
    dv_in.neg_dir = sq_q[ROOT_W].neg_dir;
    dv_in.zero    = sq_q[ROOT_W].zero;
  end

  always_ff @(posedge clk_i) begin
    if (adv) dv_q[0] <= dv_in;
  end

  // One quotient bit per stage for each component
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int I = Q_W - 1 - j;
    logic [REM_W-1:0] dsh;
    sld_dv_t          nxt;
    always_comb begin
      nxt = dv_q[j];
      dsh = REM_W'(dv_q[j].den) << I;
      for (int k = 0; k < 3; k++) begin
        if (dv_q[j].rem[k] >= dsh) begin
          nxt.rem[k]    = dv_q[j].rem[k] - dsh;
          nxt.quo[k][I] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[j+1] <= nxt;
    end
  end

  // Saturate, apply direction signs and clear the units of a zero-length item
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_q[Q_W].neg_dir[k]) begin
        q_sat[k]  = (dv_q[Q_W].quo[k] > UNIT_FULL) ? UNIT_FULL : dv_q[Q_W].quo[k];
        unit_d[k] = UNIT_W'(-q_sat[k]);
      end else begin
        q_sat[k]  = (dv_q[Q_W].quo[k] > UNIT_FULL - 1'b1) ? UNIT_FULL - 1'b1
                                                          : dv_q[Q_W].quo[k];
        unit_d[k] = UNIT_W'(q_sat[k]);
      end
      if (dv_q[Q_W].zero) unit_d[k] = '0;
    end
  end

  // Shift valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= '0;
      dv_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      sq_valid_q  <= {sq_valid_q[ROOT_W-1:0], pop};
      dv_valid_q  <= {dv_valid_q[Q_W-1:0], sq_valid_q[ROOT_W]};
      out_valid_q <= dv_valid_q[Q_W];
    end
  end

  // Hold the result beat
  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_q  <= dv_q[Q_W].zero ? '0 : dv_q[Q_W].len;
      unit_q <= unit_d;
      zero_q <= dv_q[Q_W].zero;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign seg_length_o  = len_q;
  assign unit_x_o      = unit_q[0];
  assign unit_y_o      = unit_q[1];
  assign unit_z_o      = unit_q[2];
  assign zero_length_o = zero_q;

`ifndef NO_ASSERTIONS
  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && zero_q |-> len_q == '0 && unit_q[0] == '0 && unit_q[1] == '0
      && unit_q[2] == '0)
    else $error("zero-length result carries nonzero fields");

  a_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !zero_q |-> len_q != '0)
    else $error("nonzero segment gave zero length");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sq_valid_q) && $stable(dv_valid_q))
    else $error("pipeline moved during output stall");
`endif

endmodule
